FILE: src/assert_macros.svh
// Assertion macros shared by the UTF-8 decoder modules.
// Each macro checks a property on the rising edge of clock, ignored while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/utf8d_pkg.sv
// Package for the UTF-8 decoder: buffer, command and status types and the front decode function.
// Used by utf8d_ctrl, utf8d_dp and the top level; depends on nothing.
package utf8d_pkg;

   localparam logic [20:0] REPLACEMENT   = 21'h00FFFD;
   localparam logic [20:0] MIN_TWO       = 21'h000080;
   localparam logic [20:0] MIN_THREE     = 21'h000800;
   localparam logic [20:0] MIN_FOUR      = 21'h010000;
   localparam logic [20:0] SURROGATE_LO  = 21'h00D800;
   localparam logic [20:0] SURROGATE_HI  = 21'h00DFFF;
   localparam logic [20:0] MAX_CODEPOINT = 21'h10FFFF;

   // Four byte slots, oldest byte in slot zero.
   typedef logic [3:0][7:0] buf_type;

   // Outcome of examining the front of the buffer.
   typedef struct packed {
      logic        hold;   // nothing to resolve yet (empty or waiting for bytes)
      logic [2:0]  drop;   // bytes consumed by this result
      logic [20:0] cp;
      logic        err;
   } dec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // append the accepted byte
      logic step;   // emit the front result and consume its bytes
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hold;       // front cannot be resolved now
      logic out_free;   // output register can take a result
      logic is_final;   // the front result is the last one for this byte
   } sts_type;

   function automatic logic is_cont(logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // Resolves one sequence at the front of the buffer.
   function automatic dec_type decode_front(buf_type bytes, logic [2:0] count, logic last);
      dec_type     d;
      logic [7:0]  b0;
      logic [2:0]  len;
      logic        bad;
      logic [20:0] v;
      logic [20:0] minv;
      logic        ok;
      b0     = bytes[0];
      d.hold = 1'b0;
      d.drop = 3'd1;
      d.cp   = REPLACEMENT;
      d.err  = 1'b1;
      priority if (!b0[7]) begin
         len = 3'd1;
      end else if (b0[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b0[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b0[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      // Any present byte that should continue the sequence but does not.
      bad = 1'b0;
      if (count > 3'd1 && len > 3'd1 && !is_cont(bytes[1])) bad = 1'b1;
      if (count > 3'd2 && len > 3'd2 && !is_cont(bytes[2])) bad = 1'b1;
      if (count > 3'd3 && len > 3'd3 && !is_cont(bytes[3])) bad = 1'b1;
      // Assembled value and its minimum for the sequence length.
      unique case (len)
         3'd2: begin
            v    = {10'b0, b0[4:0], bytes[1][5:0]};
            minv = MIN_TWO;
         end
         3'd3: begin
            v    = {5'b0, b0[3:0], bytes[1][5:0], bytes[2][5:0]};
            minv = MIN_THREE;
         end
         default: begin
            v    = {b0[2:0], bytes[1][5:0], bytes[2][5:0], bytes[3][5:0]};
            minv = MIN_FOUR;
         end
      endcase
      ok = (v >= minv) && !(v >= SURROGATE_LO && v <= SURROGATE_HI) && (v <= MAX_CODEPOINT);
      if (count == 3'd0) begin
         d.hold = 1'b1;
      end else if (len == 3'd1) begin
         d.cp  = {13'b0, b0};
         d.err = 1'b0;
      end else if (len != 3'd0) begin
         if (!bad && count < len) begin
            // Incomplete: wait unless the string ends, else the lead alone is dropped.
            if (!last) d.hold = 1'b1;
         end else if (!bad) begin
            d.drop = len;
            if (ok) begin
               d.cp  = v;
               d.err = 1'b0;
            end
         end
      end
      return d;
   endfunction

endpackage

FILE: src/utf8d_ctrl.sv
// Controller of the UTF-8 decoder: takes a byte, then steps the datapath once per result.
// Depends on utf8d_pkg.
module utf8d_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  utf8d_pkg::sts_type sts,
   output utf8d_pkg::cmd_type cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DECODE = 1'b1;

   logic state_ff;
   logic state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.hold) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.is_final) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/utf8d_dp.sv
// Datapath of the UTF-8 decoder: byte buffer, front decode, look-ahead and output register.
// Depends on utf8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8d_dp (
   input  logic               clock,
   input  logic               reset,
   input  utf8d_pkg::cmd_type  cmd,
   output utf8d_pkg::sts_type  sts,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [20:0]        rsp_code_point,
   output logic               rsp_was_error,
   output logic               rsp_last_of_input,
   output logic               rsp_end_of_text
);

   utf8d_pkg::buf_type buf_ff, buf_in, shifted;
   logic [2:0]         cnt_ff, cnt_in, cnt_rest;
   logic               last_ff, last_in;
   utf8d_pkg::dec_type front, ahead;
   logic [2:0]         idx [4];

   logic               valid_ff, valid_in;
   logic [20:0]        cp_ff, cp_in;
   logic               err_ff, err_in;
   logic               loi_ff, loi_in;
   logic               eot_ff, eot_in;

   // Decode the front, then look at what remains after it to know whether it is final.
   always_comb begin
      front    = utf8d_pkg::decode_front(buf_ff, cnt_ff, last_ff);
      cnt_rest = cnt_ff - front.drop;
      for (int i = 0; i < 4; i++) begin
         idx[i] = 3'(i) + front.drop;
         shifted[i] = (idx[i] < 3'd4) ? buf_ff[idx[i][1:0]] : 8'h00;
      end
      ahead = utf8d_pkg::decode_front(shifted, cnt_rest, last_ff);
   end

   always_comb begin
      sts.hold     = front.hold;
      sts.out_free = !valid_ff || rsp_ready;
      sts.is_final = ahead.hold;
   end

   // Buffer update: append on load, consume on step.
   always_comb begin
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (cmd.load) begin
         buf_in[cnt_ff[1:0]] = req_data_byte;
         cnt_in              = cnt_ff + 3'd1;
         last_in             = req_last_byte;
      end else if (cmd.step) begin
         buf_in = shifted;
         cnt_in = cnt_rest;
      end
   end

   // Output register: loaded on step, cleared once the transaction is taken.
   always_comb begin
      valid_in = valid_ff;
      cp_in    = cp_ff;
      err_in   = err_ff;
      loi_in   = loi_ff;
      eot_in   = eot_ff;
      if (cmd.step) begin
         valid_in = 1'b1;
         cp_in    = front.cp;
         err_in   = front.err;
         loi_in   = ahead.hold;
         eot_in   = ahead.hold && last_ff;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 3'd0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      cp_ff  <= cp_in;
      err_ff <= err_in;
      loi_ff <= loi_in;
      eot_ff <= eot_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_code_point    = cp_ff;
   assign rsp_was_error     = err_ff;
   assign rsp_last_of_input = loi_ff;
   assign rsp_end_of_text   = eot_ff;

   // A new result never overwrites one that has not been taken.
   `ASSERT_ALWAYS(a_no_overwrite, !(cmd.step && valid_ff && !rsp_ready), "result overwritten")
   // A byte is only appended while the buffer has room.
   `ASSERT_ALWAYS(a_load_room, !cmd.load || cnt_ff <= 3'd3, "buffer overflow")
   // The final result of a string leaves the buffer empty.
   `ASSERT_NEXT(a_flush_empty, cmd.step && ahead.hold && last_ff, cnt_ff == 3'd0,
      "bytes left after end of string")

endmodule

FILE: src/utf8_to_code_point_decoder.sv
// UTF-8 to code point decoder, top level; joins utf8d_ctrl and utf8d_dp, uses utf8d_pkg.
// Bytes arrive one per transaction on the req_ channel, each marked when it ends the string,
// and code points leave on the rsp_ channel, U+FFFD with was_error set for malformed input.
// Up to three bytes of an incomplete sequence are held between transactions. A byte is
// accepted, then the controller steps the datapath once per result it causes, or idles
// when it causes none. The front decode resolves one sequence per cycle while the output
// register can take a result, and a look-ahead decode marks the last. The output register
// lets the next byte be accepted while the last result still waits to be taken.
module utf8_to_code_point_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_was_error,
   output logic        rsp_last_of_input,
   output logic        rsp_end_of_text
);

   utf8d_pkg::cmd_type cmd;
   utf8d_pkg::sts_type sts;

   utf8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   utf8d_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_was_error     (rsp_was_error),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_text   (rsp_end_of_text)
   );

endmodule
